// ----- src/hsv_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
// No dependencies; every other file in src uses it.
package hsv_pkg;

    localparam logic [12:0] HUE_FULL_TURN  = 13'd5760;
    localparam logic [12:0] HUE_PER_SECTOR = 13'd960;
    localparam logic [7:0]  UNIT_LEVEL     = 8'd255;
    // 255 * 960, full scale of the q/t numerator
    localparam logic [17:0] FRAC_SCALE     = 18'd244800;
    // floor(2^32 / 244800); estimate is exact or one low
    localparam logic [14:0] FRAC_RECIP     = 15'd17544;
    localparam int          RECIP_SHIFT    = 32;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    typedef struct packed {
        logic [12:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  value;
    } t_hsv;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    // after hue split
    typedef struct packed {
        logic [2:0] sector;
        logic [9:0] frac;
        logic [7:0] sat;
        logic [7:0] val;
    } t_sect;

    // after level numerators are formed
    typedef struct packed {
        logic [2:0]  sector;
        logic        gray;
        logic [7:0]  val;
        logic [7:0]  p;
        logic [25:0] nq;
        logic [25:0] nt;
    } t_level;

endpackage

// ----- src/hsv_sector.sv -----
// Stage 1: hue wrap and split into sector and in-sector fraction.
// Depends on hsv_pkg.
module hsv_sector (
    input  logic              i_clk,
    input  hsv_pkg::t_pipe_en i_en,
    input  hsv_pkg::t_hsv     i_pix,
    output hsv_pkg::t_sect    o_sect
);

    logic [12:0] hue_w;
    logic [12:0] base;
    logic [12:0] frac_w;
    logic [2:0]  sector;
    hsv_pkg::t_sect r_sect;
    hsv_pkg::t_sect n_sect;

    always_comb begin
        hue_w = (i_pix.hue >= hsv_pkg::HUE_FULL_TURN) ? 13'd0 : i_pix.hue;
        priority if (hue_w >= 13'(5 * hsv_pkg::HUE_PER_SECTOR)) begin
            sector = hsv_pkg::SECTOR_5;
            base   = 13'(5 * hsv_pkg::HUE_PER_SECTOR);
        end else if (hue_w >= 13'(4 * hsv_pkg::HUE_PER_SECTOR)) begin
            sector = hsv_pkg::SECTOR_4;
            base   = 13'(4 * hsv_pkg::HUE_PER_SECTOR);
        end else if (hue_w >= 13'(3 * hsv_pkg::HUE_PER_SECTOR)) begin
            sector = hsv_pkg::SECTOR_3;
            base   = 13'(3 * hsv_pkg::HUE_PER_SECTOR);
        end else if (hue_w >= 13'(2 * hsv_pkg::HUE_PER_SECTOR)) begin
            sector = hsv_pkg::SECTOR_2;
            base   = 13'(2 * hsv_pkg::HUE_PER_SECTOR);
        end else if (hue_w >= hsv_pkg::HUE_PER_SECTOR) begin
            sector = hsv_pkg::SECTOR_1;
            base   = hsv_pkg::HUE_PER_SECTOR;
        end else begin
            sector = hsv_pkg::SECTOR_0;
            base   = 13'd0;
        end
        frac_w        = hue_w - base;
        n_sect.sector = sector;
        n_sect.frac   = frac_w[9:0];
        n_sect.sat    = i_pix.saturation;
        n_sect.val    = i_pix.value;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_sect <= n_sect;
        end
    end

    assign o_sect = r_sect;

endmodule

// ----- src/hsv_levels.sv -----
// Stages 2-3: products for p, q and t, then the q/t numerators and p itself.
// Depends on hsv_pkg.
module hsv_levels (
    input  logic              i_clk,
    input  hsv_pkg::t_pipe_en i_en,
    input  hsv_pkg::t_sect    i_sect,
    output hsv_pkg::t_level   o_level
);

    // stage 2 registers
    logic [2:0]  r2_sector;
    logic [7:0]  r2_val;
    logic        r2_gray;
    logic [17:0] r2_sf;
    logic [17:0] r2_st;
    logic [15:0] r2_pn;

    logic [9:0]  frac_c;
    logic [7:0]  sat_c;
    logic [17:0] keep_q;
    logic [17:0] keep_t;
    logic [15:0] p_sum;
    hsv_pkg::t_level r3_level;
    hsv_pkg::t_level n3_level;

    assign frac_c = 10'(hsv_pkg::HUE_PER_SECTOR) - i_sect.frac;
    assign sat_c  = hsv_pkg::UNIT_LEVEL - i_sect.sat;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_sector <= i_sect.sector;
            r2_val    <= i_sect.val;
            r2_gray   <= (i_sect.sat == 8'd0);
            r2_sf     <= 18'(i_sect.sat) * 18'(i_sect.frac);
            r2_st     <= 18'(i_sect.sat) * 18'(frac_c);
            r2_pn     <= 16'(i_sect.val) * 16'(sat_c);
        end
    end

    // x / 255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
    always_comb begin
        keep_q             = hsv_pkg::FRAC_SCALE - r2_sf;
        keep_t             = hsv_pkg::FRAC_SCALE - r2_st;
        p_sum              = r2_pn + {8'd0, r2_pn[15:8]} + 16'd1;
        n3_level.sector    = r2_sector;
        n3_level.gray      = r2_gray;
        n3_level.val       = r2_val;
        n3_level.p         = p_sum[15:8];
        n3_level.nq        = 26'(r2_val) * 26'(keep_q);
        n3_level.nt        = 26'(r2_val) * 26'(keep_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_level <= n3_level;
        end
    end

    assign o_level = r3_level;

endmodule

// ----- src/hsv_divide.sv -----
// Stages 4-6: divide q/t numerators by 255*960 (reciprocal plus one-step
// correction), then the six-sector output mux. Depends on hsv_pkg.
module hsv_divide (
    input  logic              i_clk,
    input  hsv_pkg::t_pipe_en i_en,
    input  hsv_pkg::t_level   i_level,
    output hsv_pkg::t_rgb     o_rgb
);

    localparam int PW = 26 + 15;

    logic [PW-1:0] prod_q;
    logic [PW-1:0] prod_t;

    // stage 4
    hsv_pkg::t_level r4_level;
    logic [7:0]      r4_eq;
    logic [7:0]      r4_et;
    // stage 5
    hsv_pkg::t_level r5_level;
    logic [7:0]      r5_eq;
    logic [7:0]      r5_et;
    logic [25:0]     r5_bq;
    logic [25:0]     r5_bt;
    // stage 6
    logic [25:0]     rem_q;
    logic [25:0]     rem_t;
    logic [7:0]      q;
    logic [7:0]      t;
    hsv_pkg::t_rgb   r_rgb;
    hsv_pkg::t_rgb   n_rgb;

    assign prod_q = PW'(i_level.nq) * PW'(hsv_pkg::FRAC_RECIP);
    assign prod_t = PW'(i_level.nt) * PW'(hsv_pkg::FRAC_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_level <= i_level;
            r4_eq    <= prod_q[hsv_pkg::RECIP_SHIFT +: 8];
            r4_et    <= prod_t[hsv_pkg::RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r5_level <= r4_level;
            r5_eq    <= r4_eq;
            r5_et    <= r4_et;
            r5_bq    <= 26'(r4_eq) * 26'(hsv_pkg::FRAC_SCALE);
            r5_bt    <= 26'(r4_et) * 26'(hsv_pkg::FRAC_SCALE);
        end
    end

    // estimate is the quotient or one below it
    always_comb begin
        rem_q = r5_level.nq - r5_bq;
        rem_t = r5_level.nt - r5_bt;
        q     = r5_eq + 8'((rem_q >= 26'(hsv_pkg::FRAC_SCALE)) ? 1 : 0);
        t     = r5_et + 8'((rem_t >= 26'(hsv_pkg::FRAC_SCALE)) ? 1 : 0);
        if (r5_level.gray) begin
            n_rgb = '{red: r5_level.val, green: r5_level.val, blue: r5_level.val};
        end else begin
            unique case (r5_level.sector)
                hsv_pkg::SECTOR_0: n_rgb = '{red: r5_level.val, green: t, blue: r5_level.p};
                hsv_pkg::SECTOR_1: n_rgb = '{red: q, green: r5_level.val, blue: r5_level.p};
                hsv_pkg::SECTOR_2: n_rgb = '{red: r5_level.p, green: r5_level.val, blue: t};
                hsv_pkg::SECTOR_3: n_rgb = '{red: r5_level.p, green: q, blue: r5_level.val};
                hsv_pkg::SECTOR_4: n_rgb = '{red: t, green: r5_level.p, blue: r5_level.val};
                default:           n_rgb = '{red: r5_level.val, green: r5_level.p, blue: q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, top level: six-stage pipeline, one item per cycle while the output is not stalled.
// The pipeline holds small products, the 26x15 reciprocal multiplies for q
// and t, and their correction.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// Depends on hsv_pkg, hsv_sector, hsv_levels, hsv_divide.
module hsv_to_rgb_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel
    input  logic          i_valid,
    output logic          o_stall,
    input  hsv_pkg::t_hsv i_data,
    // output channel
    output logic          o_valid,
    input  logic          i_stall,
    output hsv_pkg::t_rgb o_data
);

    // Stage valid bits, index 0 is stage 1, index 5 is the output register.
    logic [5:0] r_vld;
    logic [5:0] n_vld;
    logic [5:0] ready;
    logic [5:0] up_vld;

    hsv_pkg::t_pipe_en en;
    hsv_pkg::t_sect    sect;
    hsv_pkg::t_level   level;

    // A stage may load when it is empty or its content moves on this cycle.
    // Bubbles collapse, so upstream keeps filling while the output waits.
    always_comb begin
        ready[5] = !r_vld[5] || !i_stall;
        for (int k = 4; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k + 1];
        end
    end

    assign up_vld = {r_vld[4:0], i_valid};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_vld[k] = ready[k] ? up_vld[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign en.s1 = ready[0];
    assign en.s2 = ready[1];
    assign en.s3 = ready[2];
    assign en.s4 = ready[3];
    assign en.s5 = ready[4];
    assign en.s6 = ready[5];

    // stage 1: hue wrap, sector and fraction
    hsv_sector u_sector (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pix  (i_data),
        .o_sect (sect)
    );

    // stages 2-3: p, and numerators for q and t
    hsv_levels u_levels (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_sect  (sect),
        .o_level (level)
    );

    // stages 4-6: constant divide and sector mux into the output register
    hsv_divide u_divide (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_level (level),
        .o_rgb   (o_data)
    );

    assign o_stall = !ready[0];
    assign o_valid = r_vld[5];

endmodule

// ----- test/hsv_rgb_checker.sv -----
// Checker for the HSV to RGB converter: watches both item channels,
// predicts each RGB pixel from the accepted HSV pixel and compares in order.
// Depends on hsv_pkg for the pixel types and the hue/level constants.
module hsv_rgb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  hsv_pkg::t_hsv i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  hsv_pkg::t_rgb i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);

    // expected pixels waiting for the result side, oldest at exp_rd
    localparam int EXP_DEPTH = 64;

    hsv_pkg::t_rgb exp_mem [EXP_DEPTH];
    logic [5:0]    exp_wr    = '0;
    logic [5:0]    exp_rd    = '0;
    int            exp_count = 0;
    int            fails     = 0;
    int            checked   = 0;

    assign o_fail_count = fails;
    assign o_pending    = exp_count;
    assign o_checked    = checked;

    // integer HSV to RGB; every level is the truncated exact fraction of value
    function automatic hsv_pkg::t_rgb convert_hsv(hsv_pkg::t_hsv px);
        int unsigned   hue_u, sat, val, full, lvl_p, lvl_q, lvl_t;
        logic [2:0]    sector;
        int unsigned   frac;
        hsv_pkg::t_rgb rgb;
        hue_u = px.hue;
        sat   = px.saturation;
        val   = px.value;
        full  = hsv_pkg::FRAC_SCALE;
        if (hue_u >= hsv_pkg::HUE_FULL_TURN) begin
            hue_u = 0;
        end
        sector = 3'(hue_u / hsv_pkg::HUE_PER_SECTOR);
        frac   = hue_u % hsv_pkg::HUE_PER_SECTOR;
        lvl_p  = (val * (hsv_pkg::UNIT_LEVEL - sat)) / hsv_pkg::UNIT_LEVEL;
        lvl_q  = (val * (full - sat * frac)) / full;
        lvl_t  = (val * (full - sat * (hsv_pkg::HUE_PER_SECTOR - frac))) / full;
        if (sat == 0) begin
            rgb = {val[7:0], val[7:0], val[7:0]};
        end else begin
            case (sector)
                hsv_pkg::SECTOR_0: rgb = {val[7:0], lvl_t[7:0], lvl_p[7:0]};
                hsv_pkg::SECTOR_1: rgb = {lvl_q[7:0], val[7:0], lvl_p[7:0]};
                hsv_pkg::SECTOR_2: rgb = {lvl_p[7:0], val[7:0], lvl_t[7:0]};
                hsv_pkg::SECTOR_3: rgb = {lvl_p[7:0], lvl_q[7:0], val[7:0]};
                hsv_pkg::SECTOR_4: rgb = {lvl_t[7:0], lvl_p[7:0], val[7:0]};
                default:           rgb = {val[7:0], lvl_p[7:0], lvl_q[7:0]};
            endcase
        end
        return rgb;
    endfunction

    task automatic compare_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        hsv_pkg::t_rgb want;
        if (i_rst_n) begin
            // result side first; latency keeps a same-cycle store out of the way
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (exp_count == 0) begin
                    fails++;
                    $display("%0t: unexpected pixel, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want      = exp_mem[exp_rd];
                    exp_rd    = exp_rd + 6'd1;
                    exp_count = exp_count - 1;
                    compare_channel("red",   want.red,   i_out_data.red);
                    compare_channel("green", want.green, i_out_data.green);
                    compare_channel("blue",  want.blue,  i_out_data.blue);
                    checked++;
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (exp_count == EXP_DEPTH) begin
                    fails++;
                    $display("%0t: too many pixels in flight, expected at most %0d, actual %0d",
                             $time, EXP_DEPTH, exp_count + 1);
                end else begin
                    exp_mem[exp_wr] = convert_hsv(i_in_data);
                    exp_wr          = exp_wr + 6'd1;
                    exp_count       = exp_count + 1;
                end
            end
        end
    end

endmodule

// ----- test/hsv_to_rgb_converter_tb.sv -----
// Testbench top for hsv_to_rgb_converter: drives HSV items, idles and stalls
// both channels in bursts, and reports the verdict from hsv_rgb_checker.
// Depends on hsv_pkg, hsv_to_rgb_converter and hsv_rgb_checker.
module hsv_to_rgb_converter_tb;

    // cycles with no item moving on either channel before giving up
    localparam int STALL_LIMIT  = 500;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 400;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    hsv_pkg::t_hsv in_data;
    logic          out_valid;
    logic          out_stall;
    hsv_pkg::t_rgb out_data;

    int   fail_count;
    int   pending;
    int   checked;

    // set while bursts of idling are wanted on both sides
    logic allow_idle;
    int   quiet_cycles = 0;
    int   n_sent;
    int   n_wrapped;
    int   n_gray;

    hsv_to_rgb_converter DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    hsv_rgb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random pixel, biased toward the interesting corners: mostly legal hues,
    // a share of wrapped hues, sector edges, and extreme saturation/value.
    function automatic hsv_pkg::t_hsv random_pixel();
        hsv_pkg::t_hsv px;
        int unsigned   pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            px.hue = 13'($urandom_range(0, 5759));
        end else if (pick < 15) begin
            px.hue = 13'($urandom_range(5760, 8191));
        end else if (pick < 18) begin
            // first or last hue of a sector
            px.hue = 13'(960 * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 959 : 0));
        end else begin
            px.hue = 13'($urandom_range(0, 8191));
        end
        case ($urandom_range(0, 9))
            0:       px.saturation = 8'd0;
            1:       px.saturation = 8'd255;
            2:       px.saturation = 8'd1;
            default: px.saturation = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       px.value = 8'd0;
            1:       px.value = 8'd255;
            default: px.value = 8'($urandom_range(0, 255));
        endcase
        return px;
    endfunction

    // Present one item at a falling edge, maybe after an idle burst with junk
    // data on the bus, then hold it until a rising edge sees no stall.
    task automatic send_pixel(input hsv_pkg::t_hsv px);
        @(negedge clk);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) begin
                in_data = random_pixel();
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_data  = px;
        do begin
            @(posedge clk);
        end while (in_stall !== 1'b0);
        n_sent++;
        if (px.hue >= hsv_pkg::HUE_FULL_TURN) n_wrapped++;
        if (px.saturation == 8'd0) n_gray++;
    endtask

    // Hold off the sender until the pipeline has handed back everything.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Result side back-pressure: random stall bursts while idling is allowed.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (allow_idle && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Watchdog: a run where no item moves for too long has hung.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout at %0t: %0d pixels still owed", $time, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        allow_idle   = 1'b1;
        n_sent       = 0;
        n_wrapped    = 0;
        n_gray       = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sector edges, hue wrap at and beyond a full turn,
        // gray pixels, zero and full value, field extremes.
        send_pixel({13'd0,    8'd255, 8'd255});
        send_pixel({13'd959,  8'd255, 8'd255});
        send_pixel({13'd960,  8'd255, 8'd255});
        send_pixel({13'd1919, 8'd200, 8'd255});
        send_pixel({13'd1920, 8'd255, 8'd180});
        send_pixel({13'd2879, 8'd128, 8'd255});
        send_pixel({13'd2880, 8'd255, 8'd255});
        send_pixel({13'd3840, 8'd255, 8'd255});
        send_pixel({13'd4800, 8'd255, 8'd255});
        send_pixel({13'd5759, 8'd255, 8'd255});
        send_pixel({13'd5760, 8'd255, 8'd255});
        send_pixel({13'd8191, 8'd128, 8'd200});
        send_pixel({13'd6000, 8'd1,   8'd255});
        send_pixel({13'd3000, 8'd0,   8'd137});
        send_pixel({13'd8191, 8'd0,   8'd255});
        send_pixel({13'd480,  8'd255, 8'd0});
        send_pixel({13'd1440, 8'd1,   8'd1});
        send_pixel({13'd4321, 8'd254, 8'd254});
        send_pixel({13'd2400, 8'd255, 8'd128});
        send_pixel({13'd0,    8'd0,   8'd0});
        drain_pipeline();

        // Random part; a full drain in the middle, no idling near the end
        // so the pipeline also runs back to back.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_pipeline();
            if (i == RANDOM_ITEMS - 60) allow_idle = 1'b0;
            send_pixel(random_pixel());
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d pixels sent, %0d checked; %0d with wrapped hue, %0d gray.",
                 n_sent, checked, n_wrapped, n_gray);
        $display("All six sectors and their edges, idle/stall bursts and a full drain.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
